>>> hw/rtl/sbq_pkg.sv
// ----------------------------------------------------------------------------
// sbq_pkg: shared types and constants of the stereo biquad filter
// Holds the sample, coefficient and accumulator widths, the register indexes,
// the history record kept per channel, and the round-and-saturate function.
// ----------------------------------------------------------------------------
package sbq_pkg;

	// Number of channels with a history record of their own.
	localparam int NUM_CHANNELS = 2;
	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	// Field widths.
	localparam int SAMPLE_W  = 24;
	localparam int COEF_W    = 32;
	localparam int FRAC_BITS = 28;
	localparam int PROD_W    = COEF_W + SAMPLE_W;
	// Five products of at most 2^54 in magnitude fit easily in 59 bits.
	localparam int ACC_W     = PROD_W + 3;
	localparam int QUOT_W    = ACC_W - FRAC_BITS;

	// Configuration register indexes.
	localparam int CFG_AW = 3;
	localparam logic [CFG_AW-1:0] REG_B0 = 3'd0;
	localparam logic [CFG_AW-1:0] REG_B1 = 3'd1;
	localparam logic [CFG_AW-1:0] REG_B2 = 3'd2;
	localparam logic [CFG_AW-1:0] REG_A1 = 3'd3;
	localparam logic [CFG_AW-1:0] REG_A2 = 3'd4;

	// Coefficient reset values: unity pass-through.
	localparam logic signed [COEF_W-1:0] COEF_ONE  = 32'sh1000_0000;
	localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;

	// Rounding constant and saturation limits.
	localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [QUOT_W-1:0] QUOT_MAX   = QUOT_W'((1 <<< (SAMPLE_W - 1)) - 1);
	localparam logic signed [QUOT_W-1:0] QUOT_MIN   = -QUOT_W'(1 <<< (SAMPLE_W - 1));

	// History record of one channel.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] ih1;
		logic signed [SAMPLE_W-1:0] ih2;
		logic signed [SAMPLE_W-1:0] oh1;
		logic signed [SAMPLE_W-1:0] oh2;
	} hist_t;

	// Round half up, drop the fraction bits and clamp to the sample range.
	function automatic logic signed [SAMPLE_W-1:0] round_sat(
		input logic signed [ACC_W-1:0] acc
	);
		logic signed [ACC_W-1:0]  biased;
		logic signed [QUOT_W-1:0] quot;
		biased = acc + ROUND_HALF;
		quot   = biased[ACC_W-1:FRAC_BITS];
		if (quot > QUOT_MAX) begin
			return QUOT_MAX[SAMPLE_W-1:0];
		end else if (quot < QUOT_MIN) begin
			return QUOT_MIN[SAMPLE_W-1:0];
		end
		return quot[SAMPLE_W-1:0];
	endfunction

endpackage

>>> hw/rtl/stereo_biquad_filter_top.sv
// ----------------------------------------------------------------------------
// stereo_biquad_filter_top: direct form I biquad with per-channel history
// Input words carry a signed 24-bit sample and a channel tag; each one yields
// one filtered, rounded and saturated output word.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on in_valid/in_ready with sample_in and channel, output
//   words leave on out_valid/out_ready with sample_out. Coefficients b0, b1, b2,
//   a1 and a2 (signed Q4.28) are written through cfg_wr_en/cfg_addr/cfg_wdata;
//   the user must write them only while the filter is idle, which the block
//   itself does not enforce. A write to an unknown index is dropped.
//   The four history values of a channel live in one memory entry that is read
//   at acceptance and written back in the last stage, so a word for a channel
//   waits until the previous word of that channel has written back. Words of
//   different channels follow one another in consecutive cycles while no
//   stage ahead of them stalls.
//   The five products are formed by one multiplier in each of stages 1 to 5
//   of a six-stage pipeline with a running accumulator.
//   Reset clears the coefficients to unity pass-through and marks every
//   history entry as zero. When the receiver stalls, the output register
//   holds its word and the pipeline fills up behind it; input is still taken
//   while empty stages remain and no word of its channel is in flight.
// ----------------------------------------------------------------------------
module stereo_biquad_filter_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port.
	input  logic                                cfg_wr_en,
	input  logic [sbq_pkg::CFG_AW-1:0]          cfg_addr,
	input  logic [sbq_pkg::COEF_W-1:0]          cfg_wdata,
	// Input channel.
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [sbq_pkg::SAMPLE_W-1:0] sample_in,
	input  logic                                channel,
	// Output channel.
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [sbq_pkg::SAMPLE_W-1:0] sample_out
);

	// Coefficient registers.
	logic signed [sbq_pkg::COEF_W-1:0] coef_b0_q;
	logic signed [sbq_pkg::COEF_W-1:0] coef_b1_q;
	logic signed [sbq_pkg::COEF_W-1:0] coef_b2_q;
	logic signed [sbq_pkg::COEF_W-1:0] coef_a1_q;
	logic signed [sbq_pkg::COEF_W-1:0] coef_a2_q;

	// History memory and its per-entry valid bits.
	sbq_pkg::hist_t                    hist_mem_q [sbq_pkg::NUM_CHANNELS];
	logic [sbq_pkg::NUM_CHANNELS-1:0]  hist_vld_q;

	// Pipeline stage registers.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [sbq_pkg::CH_W-1:0] ch_s1, ch_s2, ch_s3, ch_s4, ch_s5, ch_s6;
	logic signed [sbq_pkg::SAMPLE_W-1:0] x_s1, x_s2, x_s3, x_s4, x_s5, x_s6;
	sbq_pkg::hist_t hist_rd_s1;
	logic           hist_rd_vld_s1;
	sbq_pkg::hist_t hist_s2, hist_s3, hist_s4, hist_s5, hist_s6;
	logic signed [sbq_pkg::PROD_W-1:0] prod_s1, prod_s2, prod_s3, prod_s4, prod_s5;
	logic signed [sbq_pkg::ACC_W-1:0]  acc_s2, acc_s3, acc_s4, acc_s5, acc_s6;

	// Output register.
	logic                                out_valid_q;
	logic signed [sbq_pkg::SAMPLE_W-1:0] sample_out_q;

	// Control.
	logic adv1, adv2, adv3, adv4, adv5, adv6;
	logic [sbq_pkg::CH_W-1:0] ch_in;
	logic hazard;
	logic in_fire;
	logic wb_en;
	sbq_pkg::hist_t hist_cur;
	sbq_pkg::hist_t hist_new;
	logic signed [sbq_pkg::SAMPLE_W-1:0] y_s6;

	// Channel tag folded onto the number of channels.
	assign ch_in = (sbq_pkg::NUM_CHANNELS == 1) ? '0 : sbq_pkg::CH_W'(channel);

	// Stage k may move on when stage k+1 is empty or moving itself.
	assign adv6 = !out_valid_q || out_ready;
	assign adv5 = !vld_s6 || adv6;
	assign adv4 = !vld_s5 || adv5;
	assign adv3 = !vld_s4 || adv4;
	assign adv2 = !vld_s3 || adv3;
	assign adv1 = !vld_s2 || adv2;

	// A word waits while another word of its channel is still in flight.
	assign hazard = (vld_s1 && ch_s1 == ch_in) || (vld_s2 && ch_s2 == ch_in)
		|| (vld_s3 && ch_s3 == ch_in) || (vld_s4 && ch_s4 == ch_in)
		|| (vld_s5 && ch_s5 == ch_in) || (vld_s6 && ch_s6 == ch_in);

	assign in_ready = (!vld_s1 || adv1) && !hazard;
	assign in_fire  = in_valid && in_ready;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_b0_q <= sbq_pkg::COEF_ONE;
			coef_b1_q <= sbq_pkg::COEF_ZERO;
			coef_b2_q <= sbq_pkg::COEF_ZERO;
			coef_a1_q <= sbq_pkg::COEF_ZERO;
			coef_a2_q <= sbq_pkg::COEF_ZERO;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				sbq_pkg::REG_B0: coef_b0_q <= cfg_wdata;
				sbq_pkg::REG_B1: coef_b1_q <= cfg_wdata;
				sbq_pkg::REG_B2: coef_b2_q <= cfg_wdata;
				sbq_pkg::REG_A1: coef_a1_q <= cfg_wdata;
				sbq_pkg::REG_A2: coef_a2_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (in_fire) begin
				vld_s1 <= 1'b1;
			end else if (adv1) begin
				vld_s1 <= 1'b0;
			end
			if (adv1) vld_s2 <= vld_s1;
			if (adv2) vld_s3 <= vld_s2;
			if (adv3) vld_s4 <= vld_s3;
			if (adv4) vld_s5 <= vld_s4;
			if (adv5) vld_s6 <= vld_s5;
		end
	end

	// Stage 1: history read and the b0 product of the incoming sample.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			ch_s1          <= ch_in;
			x_s1           <= sample_in;
			prod_s1        <= sbq_pkg::PROD_W'(coef_b0_q) * sbq_pkg::PROD_W'(sample_in);
			hist_rd_s1     <= hist_mem_q[ch_in];
			hist_rd_vld_s1 <= hist_vld_q[ch_in];
		end
	end

	// An entry never written since reset reads as zero history.
	assign hist_cur = hist_rd_vld_s1 ? hist_rd_s1 : '0;

	// Stages 2 to 6: a product in each of stages 2 to 5, each accumulated one stage later.
	always_ff @(posedge clk) begin
		if (adv1 && vld_s1) begin
			ch_s2   <= ch_s1;
			x_s2    <= x_s1;
			hist_s2 <= hist_cur;
			acc_s2  <= sbq_pkg::ACC_W'(prod_s1);
			prod_s2 <= sbq_pkg::PROD_W'(coef_b1_q) * sbq_pkg::PROD_W'(hist_cur.ih1);
		end
		if (adv2 && vld_s2) begin
			ch_s3   <= ch_s2;
			x_s3    <= x_s2;
			hist_s3 <= hist_s2;
			acc_s3  <= acc_s2 + sbq_pkg::ACC_W'(prod_s2);
			prod_s3 <= sbq_pkg::PROD_W'(coef_b2_q) * sbq_pkg::PROD_W'(hist_s2.ih2);
		end
		if (adv3 && vld_s3) begin
			ch_s4   <= ch_s3;
			x_s4    <= x_s3;
			hist_s4 <= hist_s3;
			acc_s4  <= acc_s3 + sbq_pkg::ACC_W'(prod_s3);
			prod_s4 <= sbq_pkg::PROD_W'(coef_a1_q) * sbq_pkg::PROD_W'(hist_s3.oh1);
		end
		if (adv4 && vld_s4) begin
			ch_s5   <= ch_s4;
			x_s5    <= x_s4;
			hist_s5 <= hist_s4;
			acc_s5  <= acc_s4 - sbq_pkg::ACC_W'(prod_s4);
			prod_s5 <= sbq_pkg::PROD_W'(coef_a2_q) * sbq_pkg::PROD_W'(hist_s4.oh2);
		end
		if (adv5 && vld_s5) begin
			ch_s6   <= ch_s5;
			x_s6    <= x_s5;
			hist_s6 <= hist_s5;
			acc_s6  <= acc_s5 - sbq_pkg::ACC_W'(prod_s5);
		end
	end

	// Final stage: round, saturate and build the shifted history record.
	assign y_s6  = sbq_pkg::round_sat(acc_s6);
	assign wb_en = vld_s6 && adv6;

	always_comb begin
		hist_new.ih1 = x_s6;
		hist_new.ih2 = hist_s6.ih1;
		hist_new.oh1 = y_s6;
		hist_new.oh2 = hist_s6.oh1;
	end

	// History write-back.
	always_ff @(posedge clk) begin
		if (wb_en) begin
			hist_mem_q[ch_s6] <= hist_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
		end else if (wb_en) begin
			hist_vld_q[ch_s6] <= 1'b1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wb_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_en) begin
			sample_out_q <= y_s6;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	// An accepted word always lands in the first stage.
	assert property (@(posedge clk) disable iff (!arst_n) in_fire |=> vld_s1)
		else $error("accepted word did not enter stage 1");

	// A word held in the last stage keeps its accumulated sum.
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s6 && !adv6) |=> (vld_s6 && $stable(acc_s6)))
		else $error("stalled last stage lost its sum");

	// No word of a channel is read while that channel is being written back.
	assert property (@(posedge clk) disable iff (!arst_n)
		(wb_en && in_fire) |-> (ch_s6 != ch_in))
		else $error("history read overlaps write-back of the same channel");

	// Stages 1 and 2 never hold words of the same channel.
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && vld_s2) |-> (ch_s1 != ch_s2))
		else $error("two words of one channel in flight");

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the stereo biquad filter
// Drives audio words with a channel tag through the valid/ready input, loads
// several coefficient sets while the filter is idle, and compares every output
// word with a direct form I predictor that keeps its own per-channel history.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sbq_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 12;
	localparam int PHASES       = 12;
	localparam int PHASE_WORDS  = 150;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_HI = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_LO = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic signed [COEF_W-1:0]   COEF_HI   = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic signed [COEF_W-1:0]   COEF_LO   = {1'b1, {(COEF_W-1){1'b0}}};
	localparam logic signed [COEF_W-1:0]   COEF_HALF = COEF_ONE >>> 1;

	// Scoreboard: filter predictor with its own coefficients and history.
	class filter_checker;
		logic signed [COEF_W-1:0]   b0, b1, b2, a1, a2;
		logic signed [SAMPLE_W-1:0] x_z1 [NUM_CHANNELS];
		logic signed [SAMPLE_W-1:0] x_z2 [NUM_CHANNELS];
		logic signed [SAMPLE_W-1:0] y_z1 [NUM_CHANNELS];
		logic signed [SAMPLE_W-1:0] y_z2 [NUM_CHANNELS];
		logic signed [SAMPLE_W-1:0] due_samples [$];
		int errors;

		function new();
			b0 = COEF_ONE;
			b1 = COEF_ZERO;
			b2 = COEF_ZERO;
			a1 = COEF_ZERO;
			a2 = COEF_ZERO;
			foreach (x_z1[i]) begin
				x_z1[i] = '0;
				x_z2[i] = '0;
				y_z1[i] = '0;
				y_z2[i] = '0;
			end
			errors = 0;
		endfunction

		// A write to an index outside the coefficient list is dropped.
		function void set_coef(logic [CFG_AW-1:0] idx, logic signed [COEF_W-1:0] val);
			case (idx)
				REG_B0: b0 = val;
				REG_B1: b1 = val;
				REG_B2: b2 = val;
				REG_A1: a1 = val;
				REG_A2: a2 = val;
				default: ;
			endcase
		endfunction

		// Full-width sum, round half up, drop the fraction and clamp.
		function logic signed [SAMPLE_W-1:0] filter_predict(logic signed [SAMPLE_W-1:0] x,
				logic ch_bit);
			int     idx;
			longint acc;
			longint quot;
			logic signed [SAMPLE_W-1:0] y;
			idx  = int'(ch_bit) % NUM_CHANNELS;
			acc  = longint'(b0) * longint'(x)
				+ longint'(b1) * longint'(x_z1[idx])
				+ longint'(b2) * longint'(x_z2[idx])
				- longint'(a1) * longint'(y_z1[idx])
				- longint'(a2) * longint'(y_z2[idx]);
			quot = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
			if (quot > longint'(SAMPLE_HI)) begin
				y = SAMPLE_HI;
			end else if (quot < longint'(SAMPLE_LO)) begin
				y = SAMPLE_LO;
			end else begin
				y = quot[SAMPLE_W-1:0];
			end
			x_z2[idx] = x_z1[idx];
			x_z1[idx] = x;
			y_z2[idx] = y_z1[idx];
			y_z1[idx] = y;
			return y;
		endfunction

		function void accept_sample(logic signed [SAMPLE_W-1:0] x, logic ch_bit);
			due_samples.push_back(filter_predict(x, ch_bit));
		endfunction

		function void check_filtered(logic signed [SAMPLE_W-1:0] actual);
			logic signed [SAMPLE_W-1:0] expected;
			if (due_samples.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: output word %0d with none expected", $realtime, actual);
			end else begin
				expected = due_samples.pop_front();
				if (actual !== expected) begin
					errors++;
					if (errors <= 10)
						$display("%0t: sample_out expected %0d, got %0d", $realtime,
							expected, actual);
				end
			end
		endfunction

		function int pending();
			return due_samples.size();
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_wr_en;
	logic [CFG_AW-1:0]          cfg_addr;
	logic [COEF_W-1:0]          cfg_wdata;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic                       channel;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [SAMPLE_W-1:0] sample_out;

	filter_checker board = new();
	bit in_steady  = 1'b0;
	bit out_steady = 1'b0;
	int cycles     = 0;

	stereo_biquad_filter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample_in (sample_in),
		.channel   (channel),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample_out(sample_out)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Uniform coefficient in [-span, span].
	function automatic logic signed [COEF_W-1:0] coef_within(int unsigned span);
		longint v;
		v = longint'($urandom_range(0, 2 * span)) - longint'(span);
		return v[COEF_W-1:0];
	endfunction

	task automatic write_coef(input logic [CFG_AW-1:0] idx, input logic signed [COEF_W-1:0] val);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_addr  = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		board.set_coef(idx, val);
	endtask

	task automatic load_coefs(input logic signed [COEF_W-1:0] b0, b1, b2, a1, a2);
		write_coef(REG_B0, b0);
		write_coef(REG_B1, b1);
		write_coef(REG_B2, b2);
		write_coef(REG_A1, a1);
		write_coef(REG_A2, a2);
	endtask

	// Present one word after a random gap and hold it until accepted.
	task automatic send_word(input logic signed [SAMPLE_W-1:0] smp, input logic ch);
		int gap;
		if ($urandom_range(0, 39) == 0) in_steady = ~in_steady;
		gap = in_steady ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid  = 1'b1;
		sample_in = smp;
		channel   = ch;
		do @(posedge clk); while (!in_ready);
		board.accept_sample(smp, ch);
	endtask

	// Stop sending and wait until every expected word has come out.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Receiver: random stalls, with stretches of steady readiness.
	initial begin
		int stall;
		stall     = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 299) == 0) out_steady = ~out_steady;
			if (stall > 0) begin
				out_ready = 1'b0;
				stall--;
			end else begin
				out_ready = 1'b1;
				if (!out_steady && $urandom_range(0, 3) == 0) stall = pick_gap();
			end
		end
	end

	// Output monitor.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_filtered(sample_out);
	end

	// Run limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// Main sequence: directed words, then random coefficient phases.
	initial begin
		logic signed [COEF_W-1:0]   corners [6];
		logic signed [COEF_W-1:0]   cb0, cb1, cb2, ca1, ca2;
		logic signed [SAMPLE_W-1:0] smp;
		logic                       ch;
		logic                       fixed_ch;
		int                         pattern;
		int                         style;
		longint                     span;
		arst_n    = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_addr  = REG_B0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		sample_in = '0;
		channel   = 1'b0;
		corners   = '{COEF_HI, COEF_LO, COEF_ZERO, -32'sd1, COEF_ONE, -COEF_ONE};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset coefficients pass the sample through unchanged.
		send_word(SAMPLE_HI, 1'b0);
		send_word(SAMPLE_LO, 1'b1);
		send_word('0, 1'b0);
		send_word(-24'sd1, 1'b1);
		send_word(24'sd1, 1'b1);
		send_word(SAMPLE_LO, 1'b0);
		drain();

		// A gain of one half lands exactly on halves, which round upward.
		load_coefs(COEF_HALF, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
		send_word(24'sd1, 1'b0);
		send_word(-24'sd1, 1'b1);
		send_word(24'sd3, 1'b1);
		send_word(-24'sd3, 1'b0);
		drain();

		// Extreme and unstable coefficients drive the output into saturation,
		// and writes to indexes past the last register are dropped.
		load_coefs(COEF_HI, COEF_LO, -32'sd1, COEF_HI, COEF_LO);
		for (int i = REG_A2 + 1; i < 2 ** CFG_AW; i++)
			write_coef(i[CFG_AW-1:0], $urandom);
		send_word(SAMPLE_HI, 1'b0);
		send_word(SAMPLE_HI, 1'b0);
		send_word(SAMPLE_LO, 1'b1);
		send_word(SAMPLE_LO, 1'b1);
		send_word(SAMPLE_HI, 1'b1);
		send_word('0, 1'b0);
		send_word(-24'sd1, 1'b0);
		send_word(SAMPLE_LO, 1'b0);
		drain();

		// Random phases, each with a fresh coefficient set of some kind.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase % 4)
				0: begin
					cb0 = coef_within(COEF_HALF);
					cb1 = coef_within(COEF_HALF);
					cb2 = coef_within(COEF_HALF);
					ca1 = coef_within(COEF_HALF);
					ca2 = coef_within(COEF_HALF);
				end
				1: begin
					cb0 = $urandom;
					cb1 = $urandom;
					cb2 = $urandom;
					ca1 = $urandom;
					ca2 = $urandom;
				end
				2: begin
					cb0 = corners[$urandom_range(0, 5)];
					cb1 = corners[$urandom_range(0, 5)];
					cb2 = corners[$urandom_range(0, 5)];
					ca1 = corners[$urandom_range(0, 5)];
					ca2 = corners[$urandom_range(0, 5)];
				end
				default: begin
					// Stable second-order section: |a2| < 1 and |a1| < 1 + a2.
					cb0 = coef_within(COEF_ONE);
					cb1 = coef_within(COEF_ONE);
					cb2 = coef_within(COEF_ONE);
					ca2 = coef_within(int'(longint'(COEF_ONE) * 9 / 10));
					span = (longint'(COEF_ONE) + longint'(ca2)) * 95 / 100;
					ca1 = coef_within(int'(span));
				end
			endcase
			load_coefs(cb0, cb1, cb2, ca1, ca2);

			pattern  = $urandom_range(0, 2);
			fixed_ch = 1'($urandom);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				case (pattern)
					0: ch = 1'($urandom);
					1: ch = n[0];
					default: ch = fixed_ch;
				endcase
				style = $urandom_range(0, 9);
				if (style == 0) begin
					smp = $urandom_range(0, 1) ? SAMPLE_HI : SAMPLE_LO;
				end else if (style < 3) begin
					smp = SAMPLE_W'(int'($urandom_range(0, 2000)) - 1000);
				end else begin
					smp = SAMPLE_W'($urandom);
				end
				send_word(smp, ch);
			end
			drain();
		end

		if (board.errors == 0 && board.pending() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
